// ----- rtl/nbsp_pkg.sv -----
// Shared types and constants of the node-status reply parser.
package nbsp_pkg;

  localparam int unsigned COUNT_OFFSET     = 56;
  localparam int unsigned BODY_OFFSET      = 57;
  localparam int unsigned NAME_BYTES       = 14;
  localparam int unsigned UNIT_BYTES       = 6;
  localparam int unsigned TYPE_POS         = 15;
  localparam int unsigned FLAG_POS         = 16;
  localparam int unsigned ENTRY_LAST_POS   = 17;
  localparam int unsigned GROUP_FLAG_BIT   = 7;
  localparam logic [7:0]  FILE_SERVER_TYPE = 8'h20;
  localparam int unsigned QUEUE_DEPTH      = 2;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_ID,
    KIND_COUNT,
    KIND_BODY
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_SHORT,
    STATUS_ID_MISMATCH
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
  } token_t;

  typedef struct packed {
    logic [47:0] unit_id;
    logic [55:0] group_name_tail;
    logic [55:0] group_name_head;
    logic        group_found;
    logic [55:0] server_name_tail;
    logic [55:0] server_name_head;
    logic        server_found;
    logic [7:0]  entry_count;
    status_e     status;
  } result_t;

endpackage

// ----- rtl/nbsp_front.sv -----
// Front end: counts reply bytes and tags each byte with its role.
module nbsp_front #(
  parameter int unsigned MAX_PACKET_BYTES = 500
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      in_data_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  input  logic            q_ready_i,
  output logic            q_push_o,
  output nbsp_pkg::token_t q_token_o
);

  localparam int unsigned OffW = $clog2(MAX_PACKET_BYTES + 1);

  logic [OffW-1:0]  offset_q, offset_d;
  nbsp_pkg::kind_e  kind;
  logic             accept;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;
  assign q_push_o   = accept;

  always_comb begin
    if (offset_q >= OffW'(MAX_PACKET_BYTES)) begin
      kind = nbsp_pkg::KIND_NONE;
    end else if (offset_q < OffW'(2)) begin
      kind = nbsp_pkg::KIND_ID;
    end else if (offset_q == OffW'(nbsp_pkg::COUNT_OFFSET)) begin
      kind = nbsp_pkg::KIND_COUNT;
    end else if (offset_q >= OffW'(nbsp_pkg::BODY_OFFSET)) begin
      kind = nbsp_pkg::KIND_BODY;
    end else begin
      kind = nbsp_pkg::KIND_NONE;
    end
  end

  assign q_token_o = '{data: in_data_i, kind: kind, last: in_last_i};

  always_comb begin
    offset_d = offset_q;
    if (accept) begin
      if (in_last_i) begin
        offset_d = '0;
      end else if (offset_q < OffW'(MAX_PACKET_BYTES)) begin
        offset_d = offset_q + OffW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else begin
      offset_q <= offset_d;
    end
  end

endmodule

// ----- rtl/nbsp_fifo.sv -----
// Two-entry word queue between the front end and the parser back end.
module nbsp_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  nbsp_pkg::token_t push_token_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output nbsp_pkg::token_t pop_token_o
);

  nbsp_pkg::token_t mem_q [nbsp_pkg::QUEUE_DEPTH];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q, count_d;

  assign ready_o     = count_q < 2'(nbsp_pkg::QUEUE_DEPTH);
  assign valid_o     = count_q != 2'd0;
  assign pop_token_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_token_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(nbsp_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

// ----- rtl/nbsp_back.sv -----
// Back end: captures id, count, entries and unit id, and registers the result word.
module nbsp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [15:0]       transaction_id_i,
  input  logic              q_valid_i,
  input  nbsp_pkg::token_t  q_token_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  output nbsp_pkg::result_t out_result_o,
  input  logic              out_ready_i
);

  typedef struct packed {
    logic [15:0]       id;
    logic [7:0]        count;
    logic [4:0]        pos;
    logic [7:0]        done;
    logic [13:0][7:0]  name;
    logic [7:0]        etype;
    logic              gflag;
    logic              srv_found;
    logic [13:0][7:0]  srv_name;
    logic              grp_found;
    logic [13:0][7:0]  grp_name;
    logic [5:0][7:0]   unit;
    logic              body_seen;
  } parse_t;

  parse_t            st_q, st_n, st_d;
  nbsp_pkg::result_t res_d, res_q;
  nbsp_pkg::status_e status;
  logic              out_valid_q;
  logic              slot_free;
  logic              pop;

  function automatic logic [13:0][7:0] trim_name(input logic [13:0][7:0] raw);
    logic [13:0][7:0] res;
    logic             ended;
    ended = 1'b0;
    for (int i = 13; i >= 0; i--) begin
      if (raw[i] == 8'd0) begin
        ended = 1'b1;
      end
      res[i] = ended ? 8'd0 : raw[i];
    end
    return res;
  endfunction

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop       = q_valid_i && (!q_token_i.last || slot_free);
  assign q_pop_o   = pop;

  always_comb begin
    st_n = st_q;
    if (pop) begin
      case (q_token_i.kind)
        nbsp_pkg::KIND_ID: begin
          st_n.id = {st_q.id[7:0], q_token_i.data};
        end
        nbsp_pkg::KIND_COUNT: begin
          st_n.count = q_token_i.data;
        end
        nbsp_pkg::KIND_BODY: begin
          st_n.body_seen = 1'b1;
          if (st_q.done < st_q.count) begin
            if (st_q.pos < 5'(nbsp_pkg::NAME_BYTES)) begin
              st_n.name[4'd13 - st_q.pos[3:0]] = q_token_i.data;
            end else if (st_q.pos == 5'(nbsp_pkg::TYPE_POS)) begin
              st_n.etype = q_token_i.data;
            end else if (st_q.pos == 5'(nbsp_pkg::FLAG_POS)) begin
              st_n.gflag = q_token_i.data[nbsp_pkg::GROUP_FLAG_BIT];
            end
            if (st_q.pos == 5'(nbsp_pkg::ENTRY_LAST_POS)) begin
              if (st_q.gflag) begin
                if (!st_q.grp_found) begin
                  st_n.grp_found = 1'b1;
                  st_n.grp_name  = trim_name(st_q.name);
                end
              end else if (st_q.etype == nbsp_pkg::FILE_SERVER_TYPE) begin
                if (!st_q.srv_found) begin
                  st_n.srv_found = 1'b1;
                  st_n.srv_name  = trim_name(st_q.name);
                end
              end
              st_n.pos  = '0;
              st_n.done = st_q.done + 8'd1;
            end else begin
              st_n.pos = st_q.pos + 5'd1;
            end
          end else if (st_q.pos < 5'(nbsp_pkg::UNIT_BYTES)) begin
            st_n.unit[3'd5 - st_q.pos[2:0]] = q_token_i.data;
            st_n.pos = st_q.pos + 5'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (!st_n.body_seen) begin
      status = nbsp_pkg::STATUS_SHORT;
    end else if (st_n.id != transaction_id_i) begin
      status = nbsp_pkg::STATUS_ID_MISMATCH;
    end else if (st_n.done < st_n.count) begin
      status = nbsp_pkg::STATUS_SHORT;
    end else begin
      status = nbsp_pkg::STATUS_OK;
    end
    res_d = '0;
    res_d.status = status;
    if (status == nbsp_pkg::STATUS_OK) begin
      res_d.entry_count      = st_n.count;
      res_d.server_found     = st_n.srv_found;
      res_d.server_name_head = st_n.srv_name[13:7];
      res_d.server_name_tail = st_n.srv_name[6:0];
      res_d.group_found      = st_n.grp_found;
      res_d.group_name_head  = st_n.grp_name[13:7];
      res_d.group_name_tail  = st_n.grp_name[6:0];
      res_d.unit_id          = st_n.unit;
    end
  end

  assign st_d = (pop && q_token_i.last) ? '0 : st_n;

  always_ff @(posedge clk_i) begin
    if (pop && q_token_i.last) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (pop && q_token_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.pos <= 5'(nbsp_pkg::ENTRY_LAST_POS))
    else $error("entry position out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && q_token_i.last) |=> (out_valid_q && st_q.pos == 5'd0 && st_q.done == 8'd0))
    else $error("final word did not produce a result and a cleared parse state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.done <= st_q.count || st_q.count == 8'd0)
    else $error("more entries parsed than announced");

endmodule

// ----- rtl/nbstat_response_parser.sv -----
// Top level of the node-status reply parser.
// The block takes one reply byte per cycle on the slave stream, with tlast on the final byte,
// and gives one result word on the master stream after that final byte. Bytes are tagged
// by a front counter, pass through a two-word queue and are captured by the back end, so a
// byte can be taken every cycle; the result word waits in an output register while the next
// reply streams in. A final byte waits at the head of the queue while that register is still
// full, and the input stalls once the queue behind it has filled. With the output register
// free, the result word is registered in the output register as the back end takes the final
// byte from the queue. Bytes past MAX_PACKET_BYTES are dropped.
module nbstat_response_parser #(
  parameter int unsigned MAX_PACKET_BYTES = 500
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_wr_en_i,
  input  logic [15:0]  cfg_wr_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: data_byte[7:0]
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status[1:0], entry_count[9:2], server_found[10], server_name_head[66:11],
  // server_name_tail[122:67], group_found[123], group_name_head[179:124],
  // group_name_tail[235:180], unit_id[283:236], zero fill[287:284]
  output logic [287:0] m_axis_tdata
);

  logic              [15:0] transaction_id_q;
  logic              q_ready, q_push, q_valid, q_pop;
  nbsp_pkg::token_t  push_token, pop_token;
  nbsp_pkg::result_t result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transaction_id_q <= '0;
    end else if (cfg_wr_en_i) begin
      transaction_id_q <= cfg_wr_data_i;
    end
  end

  nbsp_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_data_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_token_o  (push_token)
  );

  nbsp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_token_i (push_token),
    .ready_o      (q_ready),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .pop_token_o  (pop_token)
  );

  nbsp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .transaction_id_i (transaction_id_q),
    .q_valid_i        (q_valid),
    .q_token_i        (pop_token),
    .q_pop_o          (q_pop),
    .out_valid_o      (m_axis_tvalid),
    .out_result_o     (result),
    .out_ready_i      (m_axis_tready)
  );

  assign m_axis_tdata = {4'b0000, result};

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking stream testbench for the node-status reply parser.
module tb_top;

  localparam int unsigned MAX_BYTES   = 500;
  localparam int unsigned ENTRY_BYTES = nbsp_pkg::ENTRY_LAST_POS + 1;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rx_word_t;

  typedef enum logic [1:0] {
    ENT_PLAIN,
    ENT_SERVER,
    ENT_GROUP,
    ENT_GROUP_SERVER
  } entry_kind_e;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SLOW
  } rx_mode_e;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_wr_en_i   = 1'b0;
  logic [15:0]  cfg_wr_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata  = '0;
  logic         s_axis_tlast  = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [287:0] m_axis_tdata;

  rx_word_t          byte_q[$];
  logic [7:0]        reply_q[$];
  nbsp_pkg::result_t parsed_q[$];
  int                mismatches = 0;

  // Parser state as the hardware should hold it.
  logic [15:0]  cfg_tid   = '0;
  int unsigned  rx_offset = 0;
  logic [15:0]  rx_id     = '0;
  logic [7:0]   rx_count  = '0;
  int unsigned  rx_pos    = 0;
  logic [7:0]   rx_done   = '0;
  logic [111:0] rx_name   = '0;
  logic [7:0]   rx_type   = '0;
  logic         rx_group  = 1'b0;
  logic         srv_found = 1'b0;
  logic [111:0] srv_name  = '0;
  logic         grp_found = 1'b0;
  logic [111:0] grp_name  = '0;
  logic [47:0]  rx_unit   = '0;

  logic     word_taken    = 1'b0;
  int       burst_left    = 0;
  int       gap_left      = 0;
  int       hold_requests = 0;
  int       holds_done    = 0;
  int       hold_left     = 0;
  int       mode_left     = 0;
  rx_mode_e rx_mode       = RX_OPEN;

  nbstat_response_parser #(
    .MAX_PACKET_BYTES(MAX_BYTES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [111:0] clip_name(input logic [111:0] raw);
    logic [111:0] kept;
    logic         ended;
    kept  = '0;
    ended = 1'b0;
    for (int i = 0; i < nbsp_pkg::NAME_BYTES; i++) begin
      if (raw[111 - 8 * i -: 8] == 8'h00) ended = 1'b1;
      if (!ended) kept[111 - 8 * i -: 8] = raw[111 - 8 * i -: 8];
    end
    return kept;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic fin);
    nbsp_pkg::result_t r;
    int unsigned       need;
    if (rx_offset < MAX_BYTES) begin
      if (rx_offset < 2) begin
        rx_id = {rx_id[7:0], b};
      end else if (rx_offset == nbsp_pkg::COUNT_OFFSET) begin
        rx_count = b;
      end else if (rx_offset >= nbsp_pkg::BODY_OFFSET) begin
        if (rx_done < rx_count) begin
          if (rx_pos < nbsp_pkg::NAME_BYTES) rx_name[111 - 8 * rx_pos -: 8] = b;
          else if (rx_pos == nbsp_pkg::TYPE_POS) rx_type = b;
          else if (rx_pos == nbsp_pkg::FLAG_POS) rx_group = b[nbsp_pkg::GROUP_FLAG_BIT];
          if (rx_pos == nbsp_pkg::ENTRY_LAST_POS) begin
            if (rx_group) begin
              if (!grp_found) begin
                grp_found = 1'b1;
                grp_name  = clip_name(rx_name);
              end
            end else if (rx_type == nbsp_pkg::FILE_SERVER_TYPE && !srv_found) begin
              srv_found = 1'b1;
              srv_name  = clip_name(rx_name);
            end
            rx_pos  = 0;
            rx_done = rx_done + 8'd1;
          end else begin
            rx_pos++;
          end
        end else if (rx_pos < nbsp_pkg::UNIT_BYTES) begin
          rx_unit[47 - 8 * rx_pos -: 8] = b;
          rx_pos++;
        end
      end
      rx_offset++;
    end
    if (fin) begin
      r    = '0;
      need = nbsp_pkg::BODY_OFFSET + ENTRY_BYTES * rx_count;
      if (rx_offset <= nbsp_pkg::BODY_OFFSET) begin
        r.status = nbsp_pkg::STATUS_SHORT;
      end else if (rx_id != cfg_tid) begin
        r.status = nbsp_pkg::STATUS_ID_MISMATCH;
      end else if (rx_offset < need) begin
        r.status = nbsp_pkg::STATUS_SHORT;
      end else begin
        r.status           = nbsp_pkg::STATUS_OK;
        r.entry_count      = rx_count;
        r.server_found     = srv_found;
        r.server_name_head = srv_name[111:56];
        r.server_name_tail = srv_name[55:0];
        r.group_found      = grp_found;
        r.group_name_head  = grp_name[111:56];
        r.group_name_tail  = grp_name[55:0];
        r.unit_id          = rx_unit;
      end
      parsed_q.insert(parsed_q.size(), r);
      rx_offset = 0;
      rx_id     = '0;
      rx_count  = '0;
      rx_pos    = 0;
      rx_done   = '0;
      rx_name   = '0;
      rx_type   = '0;
      rx_group  = 1'b0;
      srv_found = 1'b0;
      srv_name  = '0;
      grp_found = 1'b0;
      grp_name  = '0;
      rx_unit   = '0;
    end
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic wait_drained();
    while (byte_q.size() != 0 || s_axis_tvalid || parsed_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_tid(input logic [15:0] v);
    wait_drained();
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= v;
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    cfg_tid = v;
  endtask

  task automatic start_reply(input logic [15:0] tid, input int unsigned n);
    reply_q.delete();
    reply_q.insert(reply_q.size(), tid[15:8]);
    reply_q.insert(reply_q.size(), tid[7:0]);
    while (reply_q.size() < nbsp_pkg::COUNT_OFFSET) begin
      reply_q.insert(reply_q.size(), 8'($urandom));
    end
    reply_q.insert(reply_q.size(), 8'(n));
  endtask

  task automatic add_entry(input entry_kind_e kind, input int unsigned zero_at);
    logic [7:0] typ;
    logic [7:0] flg;
    for (int i = 0; i < nbsp_pkg::NAME_BYTES; i++) begin
      reply_q.insert(reply_q.size(), i == zero_at ? 8'h00 : 8'($urandom_range(1, 255)));
    end
    reply_q.insert(reply_q.size(), 8'($urandom));
    typ = 8'($urandom);
    flg = 8'($urandom);
    case (kind)
      ENT_SERVER: begin
        typ = nbsp_pkg::FILE_SERVER_TYPE;
        flg[nbsp_pkg::GROUP_FLAG_BIT] = 1'b0;
      end
      ENT_GROUP: begin
        flg[nbsp_pkg::GROUP_FLAG_BIT] = 1'b1;
      end
      ENT_GROUP_SERVER: begin
        typ = nbsp_pkg::FILE_SERVER_TYPE;
        flg[nbsp_pkg::GROUP_FLAG_BIT] = 1'b1;
      end
      default: begin
        if (typ == nbsp_pkg::FILE_SERVER_TYPE) typ = ~typ;
        flg[nbsp_pkg::GROUP_FLAG_BIT] = 1'b0;
      end
    endcase
    reply_q.insert(reply_q.size(), typ);
    reply_q.insert(reply_q.size(), flg);
    reply_q.insert(reply_q.size(), 8'($urandom));
  endtask

  task automatic add_bytes(input int unsigned n);
    repeat (n) reply_q.insert(reply_q.size(), 8'($urandom));
  endtask

  task automatic send_reply(input int unsigned len);
    rx_word_t w;
    while (reply_q.size() < len) reply_q.insert(reply_q.size(), 8'($urandom));
    for (int i = 0; i < len; i++) begin
      w.data = reply_q[i];
      w.last = (i == len - 1);
      byte_q.insert(byte_q.size(), w);
    end
  endtask

  task automatic random_reply();
    int unsigned n;
    int unsigned full;
    int unsigned len;
    int unsigned pick;
    logic [15:0] tid;
    pick = $urandom_range(0, 99);
    tid  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : cfg_tid;
    n    = $urandom_range(0, 3);
    start_reply(tid, n);
    for (int i = 0; i < n; i++) begin
      add_entry(entry_kind_e'($urandom_range(0, 3)),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, nbsp_pkg::NAME_BYTES - 1)
                                            : nbsp_pkg::NAME_BYTES);
    end
    full = nbsp_pkg::BODY_OFFSET + ENTRY_BYTES * n + nbsp_pkg::UNIT_BYTES;
    if (pick < 65) len = full + $urandom_range(0, 4);
    else if (pick < 80) len = full - $urandom_range(1, nbsp_pkg::UNIT_BYTES);
    else if (pick < 90) len = $urandom_range(1, full - 1);
    else len = $urandom_range(1, nbsp_pkg::BODY_OFFSET);
    send_reply(len);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      parse_byte(s_axis_tdata, s_axis_tlast);
      word_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin : feed
    rx_word_t w;
    if (rst_ni && (!s_axis_tvalid || word_taken)) begin
      word_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        w = byte_q.pop_front();
        s_axis_tdata  <= w.data;
        s_axis_tlast  <= w.last;
        s_axis_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 200);
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1: gap_left = $urandom_range(1, 3);
            2: gap_left = $urandom_range(4, 20);
            default: gap_left = 0;
          endcase
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (holds_done != hold_requests) begin
      hold_left  = HOLD_CYCLES;
      holds_done = hold_requests;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(10, 200);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN: m_axis_tready <= 1'b1;
        RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : check_out
    nbsp_pkg::result_t want;
    nbsp_pkg::result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (parsed_q.size() == 0) begin
        $display("%0t: result word expected none got %0h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = parsed_q.pop_front();
        got  = nbsp_pkg::result_t'(m_axis_tdata[283:0]);
        check_field("status", want.status, got.status);
        check_field("entry_count", want.entry_count, got.entry_count);
        check_field("server_found", want.server_found, got.server_found);
        check_field("server_name_head", want.server_name_head, got.server_name_head);
        check_field("server_name_tail", want.server_name_tail, got.server_name_tail);
        check_field("group_found", want.group_found, got.group_found);
        check_field("group_name_head", want.group_name_head, got.group_name_head);
        check_field("group_name_tail", want.group_name_tail, got.group_name_tail);
        check_field("unit_id", want.unit_id, got.unit_id);
        check_field("zero fill", '0, m_axis_tdata[287:284]);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    start_reply(16'h0000, 0);
    send_reply(1);
    start_reply(16'h5A5A, 0);
    send_reply(nbsp_pkg::BODY_OFFSET);
    start_reply(16'h1234, 0);
    send_reply(nbsp_pkg::BODY_OFFSET + 1);

    set_tid(16'hFFFF);
    start_reply(16'hFFFF, 5);
    add_entry(ENT_PLAIN, nbsp_pkg::NAME_BYTES);
    add_entry(ENT_GROUP_SERVER, nbsp_pkg::NAME_BYTES - 1);
    add_entry(ENT_SERVER, 5);
    add_entry(ENT_SERVER, nbsp_pkg::NAME_BYTES);
    add_entry(ENT_GROUP, 0);
    add_bytes(nbsp_pkg::UNIT_BYTES + 2);
    send_reply(reply_q.size());
    start_reply(16'hFFFF, 1);
    add_entry(ENT_SERVER, nbsp_pkg::NAME_BYTES);
    send_reply(nbsp_pkg::BODY_OFFSET + ENTRY_BYTES - 1);
    start_reply(16'hFFFF, 0);
    add_bytes(nbsp_pkg::UNIT_BYTES - 2);
    send_reply(reply_q.size());

    // The output side holds off while short replies pile up behind it.
    set_tid(16'($urandom));
    hold_requests++;
    repeat (30) begin
      start_reply(cfg_tid, 0);
      send_reply($urandom_range(1, 3));
    end
    random_reply();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/nbsp_pkg.sv
rtl/nbsp_front.sv
rtl/nbsp_fifo.sv
rtl/nbsp_back.sv
rtl/nbstat_response_parser.sv
tb/sv/tb_top.sv
